@@ hdl/tspr_pkg.sv @@
`timescale 1ns / 1ps
// types, constants and reduction pattern table shared by the token stack pattern reducer
package tspr_pkg;

   localparam int STACK_DEPTH_DEF = 32;
   localparam int MATCH_WINDOW    = 15;
   localparam int PATTERN_COUNT   = 13;
   localparam int PATTERN_MAX     = 15;
   localparam int RESULT_LIMIT    = 32;
   localparam int DEPTH_OUT_MAX   = 63;

   typedef logic [5:0]  class_type;
   typedef logic [15:0] line_type;

   localparam logic CMD_SHIFT = 1'b0;
   localparam logic CMD_DRAIN = 1'b1;

   localparam logic [1:0] KIND_TOP      = 2'd0;
   localparam logic [1:0] KIND_LEFTOVER = 2'd1;
   localparam logic [1:0] KIND_NO_ERROR = 2'd2;

   localparam class_type CLS_END        = 6'd0;
   localparam class_type CLS_EQ         = 6'd1;
   localparam class_type CLS_LBRK       = 6'd23;
   localparam class_type CLS_RBRK       = 6'd24;
   localparam class_type CLS_LPAR       = 6'd25;
   localparam class_type CLS_RPAR       = 6'd26;
   localparam class_type CLS_SEMI       = 6'd27;
   localparam class_type CLS_DOT        = 6'd30;
   localparam class_type CLS_VAR        = 6'd31;
   localparam class_type CLS_ID         = 6'd34;
   localparam class_type CLS_IDS        = 6'd35;
   localparam class_type CLS_SCALAR     = 6'd36;
   localparam class_type CLS_LIST       = 6'd38;
   localparam class_type CLS_HASH       = 6'd39;
   localparam class_type CLS_STATEMENT  = 6'd42;
   localparam class_type CLS_STATEMENTS = 6'd43;
   localparam class_type CLS_FUNCTION   = 6'd44;
   localparam class_type CLS_DEF        = 6'd45;
   localparam class_type CLS_ASSIGNMENT = 6'd46;
   localparam class_type CLS_CALC       = 6'd47;
   localparam class_type CLS_LOOP       = 6'd48;
   localparam class_type CLS_CHOOSE     = 6'd55;

   localparam logic [3:0] PAT_LEN [PATTERN_COUNT] = '{
      4'd5, 4'd5, 4'd5, 4'd5, 4'd4, 4'd7, 4'd7, 4'd3, 4'd4, 4'd4, 4'd4, 4'd3, 4'd4
   };

   localparam class_type PAT_RESULT [PATTERN_COUNT] = '{
      CLS_DEF, CLS_DEF, CLS_DEF, CLS_DEF, CLS_DEF, CLS_DEF, CLS_DEF,
      CLS_ID, CLS_ID, CLS_ID, CLS_ID, CLS_ID, CLS_ID
   };

   // bottom-most element of the pattern first
   localparam class_type PAT_SEQ [PATTERN_COUNT][PATTERN_MAX] = '{
      '{CLS_VAR, CLS_ID, CLS_EQ, CLS_SCALAR, CLS_SEMI, CLS_END, CLS_END, CLS_END,
        CLS_END, CLS_END, CLS_END, CLS_END, CLS_END, CLS_END, CLS_END},
      '{CLS_VAR, CLS_ID, CLS_EQ, CLS_ID, CLS_SEMI, CLS_END, CLS_END, CLS_END,
        CLS_END, CLS_END, CLS_END, CLS_END, CLS_END, CLS_END, CLS_END},
      '{CLS_VAR, CLS_ID, CLS_EQ, CLS_LIST, CLS_SEMI, CLS_END, CLS_END, CLS_END,
        CLS_END, CLS_END, CLS_END, CLS_END, CLS_END, CLS_END, CLS_END},
      '{CLS_VAR, CLS_ID, CLS_EQ, CLS_HASH, CLS_SEMI, CLS_END, CLS_END, CLS_END,
        CLS_END, CLS_END, CLS_END, CLS_END, CLS_END, CLS_END, CLS_END},
      '{CLS_VAR, CLS_ID, CLS_EQ, CLS_FUNCTION, CLS_END, CLS_END, CLS_END, CLS_END,
        CLS_END, CLS_END, CLS_END, CLS_END, CLS_END, CLS_END, CLS_END},
      '{CLS_VAR, CLS_LPAR, CLS_IDS, CLS_RPAR, CLS_EQ, CLS_ID, CLS_SEMI, CLS_END,
        CLS_END, CLS_END, CLS_END, CLS_END, CLS_END, CLS_END, CLS_END},
      '{CLS_VAR, CLS_LPAR, CLS_IDS, CLS_RPAR, CLS_EQ, CLS_LIST, CLS_SEMI, CLS_END,
        CLS_END, CLS_END, CLS_END, CLS_END, CLS_END, CLS_END, CLS_END},
      '{CLS_ID, CLS_DOT, CLS_ID, CLS_END, CLS_END, CLS_END, CLS_END, CLS_END,
        CLS_END, CLS_END, CLS_END, CLS_END, CLS_END, CLS_END, CLS_END},
      '{CLS_ID, CLS_LBRK, CLS_SCALAR, CLS_RBRK, CLS_END, CLS_END, CLS_END, CLS_END,
        CLS_END, CLS_END, CLS_END, CLS_END, CLS_END, CLS_END, CLS_END},
      '{CLS_ID, CLS_LBRK, CLS_ID, CLS_RBRK, CLS_END, CLS_END, CLS_END, CLS_END,
        CLS_END, CLS_END, CLS_END, CLS_END, CLS_END, CLS_END, CLS_END},
      '{CLS_ID, CLS_LBRK, CLS_CALC, CLS_RBRK, CLS_END, CLS_END, CLS_END, CLS_END,
        CLS_END, CLS_END, CLS_END, CLS_END, CLS_END, CLS_END, CLS_END},
      '{CLS_ID, CLS_LPAR, CLS_RPAR, CLS_END, CLS_END, CLS_END, CLS_END, CLS_END,
        CLS_END, CLS_END, CLS_END, CLS_END, CLS_END, CLS_END, CLS_END},
      '{CLS_ID, CLS_LPAR, CLS_SCALAR, CLS_RPAR, CLS_END, CLS_END, CLS_END, CLS_END,
        CLS_END, CLS_END, CLS_END, CLS_END, CLS_END, CLS_END, CLS_END}
   };

   typedef struct packed {
      logic      cmd;
      class_type token_class;
      line_type  line_number;
   } req_item_type;

   typedef struct packed {
      logic [1:0] kind;
      class_type  entry_class;
      line_type   entry_line;
      logic [5:0] stack_depth;
      logic       overflowed;
      logic       last;
   } rsp_item_type;

   typedef struct packed {
      logic push;
      logic reduce;
      logic emit_top;
      logic scan_start;
      logic scan;
      logic finish;
   } dp_cmd_type;

   typedef struct packed {
      logic match;
      logic scan_end;
   } dp_status_type;

endpackage

@@ hdl/tspr_datapath.sv @@
`timescale 1ns / 1ps
// stack registers, pattern matcher, drain scan and result register
module tspr_datapath #(
   parameter int STACK_DEPTH = tspr_pkg::STACK_DEPTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  tspr_pkg::req_item_type  req_item,
   input  tspr_pkg::dp_cmd_type    dp_cmd,
   output tspr_pkg::dp_status_type dp_status,
   output logic                    rsp_strobe,
   output tspr_pkg::rsp_item_type  rsp_item
);
   import tspr_pkg::*;

   localparam int CW    = $clog2(STACK_DEPTH + 1);
   localparam int AW    = $clog2(STACK_DEPTH);
   localparam int SW    = (CW > 6) ? CW : 6;
   localparam int LIM_W = $clog2(RESULT_LIMIT + 1);

   function automatic logic class_accepted(input class_type c);
      return (c == CLS_END) || (c == CLS_STATEMENT) || (c == CLS_STATEMENTS) ||
             (c == CLS_FUNCTION) || (c == CLS_DEF) || (c == CLS_ASSIGNMENT) ||
             (c == CLS_LOOP) || (c == CLS_CHOOSE);
   endfunction

   // index 0 is the top of stack
   class_type    cls_ff  [STACK_DEPTH];
   class_type    cls_in  [STACK_DEPTH];
   line_type     line_ff [STACK_DEPTH];
   line_type     line_in [STACK_DEPTH];
   logic [CW-1:0]    count_ff, count_in;
   logic             ovf_ff, ovf_in;
   logic [CW-1:0]    idx_ff, idx_in;
   logic             pend_valid_ff, pend_valid_in;
   class_type        pend_cls_ff, pend_cls_in;
   line_type         pend_line_ff, pend_line_in;
   logic [LIM_W-1:0] taken_ff, taken_in;
   logic             rsp_strobe_ff, rsp_strobe_in;
   rsp_item_type     rsp_ff, rsp_in;

   logic [PATTERN_COUNT-1:0] hit;
   logic [3:0]               sel_len;
   class_type                sel_result;
   logic [AW-1:0]            phys;
   class_type                scan_cls;
   line_type                 scan_line;
   logic                     leftover;
   logic [SW-1:0]            cnt_wide;
   logic [5:0]               depth_out;

   // top-of-stack pattern compare, first pattern in table order wins
   always_comb begin
      for (int r = 0; r < PATTERN_COUNT; r++) begin
         hit[r] = (int'(PAT_LEN[r]) <= MATCH_WINDOW) &&
                  (SW'(PAT_LEN[r]) <= SW'(count_ff));
         for (int j = 0; j < PATTERN_MAX; j++) begin
            if (j < int'(PAT_LEN[r])) begin
               hit[r] = hit[r] && (cls_ff[int'(PAT_LEN[r]) - 1 - j] == PAT_SEQ[r][j]);
            end
         end
      end
      sel_len    = '0;
      sel_result = CLS_END;
      for (int r = PATTERN_COUNT - 1; r >= 0; r--) begin
         if (hit[r]) begin
            sel_len    = PAT_LEN[r];
            sel_result = PAT_RESULT[r];
         end
      end
   end

   assign phys      = AW'(count_ff - CW'(1) - idx_ff);
   assign scan_cls  = cls_ff[phys];
   assign scan_line = line_ff[phys];
   assign leftover  = !class_accepted(scan_cls) && (taken_ff < LIM_W'(RESULT_LIMIT));
   assign cnt_wide  = SW'(count_ff);
   assign depth_out = (cnt_wide > SW'(DEPTH_OUT_MAX)) ? 6'(DEPTH_OUT_MAX) : cnt_wide[5:0];

   assign dp_status.match    = |hit;
   assign dp_status.scan_end = (idx_ff == count_ff);

   always_comb begin
      cls_in        = cls_ff;
      line_in       = line_ff;
      count_in      = count_ff;
      ovf_in        = ovf_ff;
      idx_in        = idx_ff;
      pend_valid_in = pend_valid_ff;
      pend_cls_in   = pend_cls_ff;
      pend_line_in  = pend_line_ff;
      taken_in      = taken_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;

      if (dp_cmd.push) begin
         if (count_ff == CW'(STACK_DEPTH)) begin
            ovf_in = 1'b1;
         end else begin
            for (int k = 1; k < STACK_DEPTH; k++) begin
               cls_in[k]  = cls_ff[k - 1];
               line_in[k] = line_ff[k - 1];
            end
            cls_in[0]  = req_item.token_class;
            line_in[0] = req_item.line_number;
            count_in   = count_ff + CW'(1);
         end
      end

      if (dp_cmd.reduce) begin
         cls_in[0]  = sel_result;
         line_in[0] = line_ff[0];
         for (int k = 1; k < STACK_DEPTH; k++) begin
            for (int l = 1; l <= PATTERN_MAX; l++) begin
               if ((int'(sel_len) == l) && (k + l - 1 < STACK_DEPTH)) begin
                  cls_in[k]  = cls_ff[k + l - 1];
                  line_in[k] = line_ff[k + l - 1];
               end
            end
         end
         count_in = count_ff - CW'(sel_len) + CW'(1);
      end

      if (dp_cmd.emit_top) begin
         rsp_strobe_in      = 1'b1;
         rsp_in.kind        = KIND_TOP;
         rsp_in.entry_class = (count_ff != '0) ? cls_ff[0] : CLS_END;
         rsp_in.entry_line  = (count_ff != '0) ? line_ff[0] : '0;
         rsp_in.stack_depth = depth_out;
         rsp_in.overflowed  = ovf_ff;
         rsp_in.last        = 1'b1;
      end

      if (dp_cmd.scan_start) begin
         idx_in        = '0;
         pend_valid_in = 1'b0;
         taken_in      = '0;
      end

      // one leftover is held back so the final one can carry last
      if (dp_cmd.scan) begin
         idx_in = idx_ff + CW'(1);
         if (leftover) begin
            if (pend_valid_ff) begin
               rsp_strobe_in      = 1'b1;
               rsp_in.kind        = KIND_LEFTOVER;
               rsp_in.entry_class = pend_cls_ff;
               rsp_in.entry_line  = pend_line_ff;
               rsp_in.stack_depth = '0;
               rsp_in.overflowed  = ovf_ff;
               rsp_in.last        = 1'b0;
            end
            pend_valid_in = 1'b1;
            pend_cls_in   = scan_cls;
            pend_line_in  = scan_line;
            taken_in      = taken_ff + LIM_W'(1);
         end
      end

      if (dp_cmd.finish) begin
         rsp_strobe_in      = 1'b1;
         rsp_in.stack_depth = '0;
         rsp_in.overflowed  = ovf_ff;
         rsp_in.last        = 1'b1;
         if (pend_valid_ff) begin
            rsp_in.kind        = KIND_LEFTOVER;
            rsp_in.entry_class = pend_cls_ff;
            rsp_in.entry_line  = pend_line_ff;
         end else begin
            rsp_in.kind        = KIND_NO_ERROR;
            rsp_in.entry_class = CLS_END;
            rsp_in.entry_line  = '0;
         end
         count_in      = '0;
         ovf_in        = 1'b0;
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         ovf_ff        <= 1'b0;
         idx_ff        <= '0;
         pend_valid_ff <= 1'b0;
         taken_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         ovf_ff        <= ovf_in;
         idx_ff        <= idx_in;
         pend_valid_ff <= pend_valid_in;
         taken_ff      <= taken_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      cls_ff       <= cls_in;
      line_ff      <= line_in;
      pend_cls_ff  <= pend_cls_in;
      pend_line_ff <= pend_line_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

@@ hdl/tspr_ctrl.sv @@
`timescale 1ns / 1ps
// controller state machine sequencing shift, reduce and drain steps
module tspr_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    req_cmd,
   input  tspr_pkg::dp_status_type dp_status,
   output logic                    busy,
   output tspr_pkg::dp_cmd_type    dp_cmd
);
   import tspr_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_SCAN
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff, busy_in;

   always_comb begin
      state_in = state_ff;
      dp_cmd   = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_cmd == CMD_SHIFT) begin
                  dp_cmd.push = 1'b1;
                  state_in    = ST_REDUCE;
               end else begin
                  dp_cmd.scan_start = 1'b1;
                  state_in          = ST_SCAN;
               end
            end
         end
         ST_REDUCE: begin
            if (dp_status.match) begin
               dp_cmd.reduce = 1'b1;
            end else begin
               dp_cmd.emit_top = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (dp_status.scan_end) begin
               dp_cmd.finish = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               dp_cmd.scan = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      busy_in = (state_in != ST_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
      end
   end

   assign busy = busy_ff;

endmodule

@@ hdl/token_stack_pattern_reducer.sv @@
`timescale 1ns / 1ps
// top level of the token stack pattern reducer
//
//   channel   ports                    handshake
//   request   start, busy, req_item    taken on start high while busy low
//   response  rsp_strobe, rsp_item     one-cycle strobe per item, no back pressure
//
// a shift keeps busy high through every reduction it triggers (one pattern
// match and pop per cycle) and the top-of-stack emit; its item strobes in the
// first cycle with busy low. a drain keeps busy high through the scan of the
// stack, one stack entry scanned per cycle, and the finish step; each leftover but the last
// strobes while busy is high, the final item in the first cycle with busy low.
// reset empties the stack and clears the overflow flag; results never stall.
module token_stack_pattern_reducer #(
   parameter int STACK_DEPTH = tspr_pkg::STACK_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  tspr_pkg::req_item_type req_item,
   output logic                   rsp_strobe,
   output tspr_pkg::rsp_item_type rsp_item
);
   import tspr_pkg::*;

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   tspr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_cmd   (req_item.cmd),
      .dp_status (dp_status),
      .busy      (busy),
      .dp_cmd    (dp_cmd)
   );

   tspr_datapath #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_item   (req_item),
      .dp_cmd     (dp_cmd),
      .dp_status  (dp_status),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// testbench for the token stack pattern reducer: shadow stack predictor, directed and random items
module testbench;
   import tspr_pkg::*;

   localparam int RULE_COUNT  = 13;
   localparam int RULE_WIDTH  = 7;
   localparam int CYCLE_LIMIT = 200000;
   localparam int TAIL_CYCLES = 40;

   localparam int RULE_LEN [RULE_COUNT] = '{5, 5, 5, 5, 4, 7, 7, 3, 4, 4, 4, 3, 4};

   localparam class_type RULE_RESULT [RULE_COUNT] = '{
      CLS_DEF, CLS_DEF, CLS_DEF, CLS_DEF, CLS_DEF, CLS_DEF, CLS_DEF,
      CLS_ID, CLS_ID, CLS_ID, CLS_ID, CLS_ID, CLS_ID
   };

   // bottom of the stack first
   localparam class_type RULE_SEQ [RULE_COUNT][RULE_WIDTH] = '{
      '{CLS_VAR, CLS_ID, CLS_EQ, CLS_SCALAR, CLS_SEMI, CLS_END, CLS_END},
      '{CLS_VAR, CLS_ID, CLS_EQ, CLS_ID, CLS_SEMI, CLS_END, CLS_END},
      '{CLS_VAR, CLS_ID, CLS_EQ, CLS_LIST, CLS_SEMI, CLS_END, CLS_END},
      '{CLS_VAR, CLS_ID, CLS_EQ, CLS_HASH, CLS_SEMI, CLS_END, CLS_END},
      '{CLS_VAR, CLS_ID, CLS_EQ, CLS_FUNCTION, CLS_END, CLS_END, CLS_END},
      '{CLS_VAR, CLS_LPAR, CLS_IDS, CLS_RPAR, CLS_EQ, CLS_ID, CLS_SEMI},
      '{CLS_VAR, CLS_LPAR, CLS_IDS, CLS_RPAR, CLS_EQ, CLS_LIST, CLS_SEMI},
      '{CLS_ID, CLS_DOT, CLS_ID, CLS_END, CLS_END, CLS_END, CLS_END},
      '{CLS_ID, CLS_LBRK, CLS_SCALAR, CLS_RBRK, CLS_END, CLS_END, CLS_END},
      '{CLS_ID, CLS_LBRK, CLS_ID, CLS_RBRK, CLS_END, CLS_END, CLS_END},
      '{CLS_ID, CLS_LBRK, CLS_CALC, CLS_RBRK, CLS_END, CLS_END, CLS_END},
      '{CLS_ID, CLS_LPAR, CLS_RPAR, CLS_END, CLS_END, CLS_END, CLS_END},
      '{CLS_ID, CLS_LPAR, CLS_SCALAR, CLS_RPAR, CLS_END, CLS_END, CLS_END}
   };

   logic         clock = 1'b0;
   logic         reset;
   logic         start;
   logic         busy;
   req_item_type req_item;
   logic         rsp_strobe;
   rsp_item_type rsp_item;

   token_stack_pattern_reducer dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   always #2 clock = ~clock;

   // shadow copy of the token stack
   class_type shadow_class [STACK_DEPTH_DEF];
   line_type  shadow_line  [STACK_DEPTH_DEF];
   int        shadow_depth = 0;
   logic      shadow_overflow = 1'b0;

   rsp_item_type expected_rsp [$];
   rsp_item_type want_rsp;
   class_type    phrase_q [$];

   int idle_pct = 0;
   int fail_count = 0;
   int cycle_count = 0;
   int shift_count = 0;
   int drain_count = 0;
   int reduce_count = 0;
   int leftover_count = 0;
   int dropped_count = 0;
   int checked_count = 0;

   function automatic logic is_accepted(input class_type cls);
      case (cls)
         CLS_END, CLS_STATEMENT, CLS_STATEMENTS, CLS_FUNCTION,
         CLS_DEF, CLS_ASSIGNMENT, CLS_LOOP, CLS_CHOOSE: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   function automatic int match_rule();
      int hit;
      for (int r = 0; r < RULE_COUNT; r++) begin
         if (RULE_LEN[r] <= shadow_depth) begin
            hit = 1;
            for (int j = 0; j < RULE_LEN[r]; j++)
               if (shadow_class[shadow_depth - RULE_LEN[r] + j] != RULE_SEQ[r][j]) hit = 0;
            if (hit != 0) return r;
         end
      end
      return RULE_COUNT;
   endfunction

   function automatic void predict_step(input req_item_type it);
      rsp_item_type r;
      int rule;
      int total;
      int produced;
      line_type keep;
      if (it.cmd == CMD_SHIFT) begin
         shift_count++;
         if (shadow_depth >= STACK_DEPTH_DEF) begin
            shadow_overflow = 1'b1;
            dropped_count++;
         end else begin
            shadow_class[shadow_depth] = it.token_class;
            shadow_line[shadow_depth]  = it.line_number;
            shadow_depth++;
         end
         rule = match_rule();
         while (rule < RULE_COUNT) begin
            keep = shadow_line[shadow_depth - 1];
            shadow_depth = shadow_depth - RULE_LEN[rule];
            shadow_class[shadow_depth] = RULE_RESULT[rule];
            shadow_line[shadow_depth]  = keep;
            shadow_depth++;
            reduce_count++;
            rule = match_rule();
         end
         r = '0;
         r.kind = KIND_TOP;
         if (shadow_depth > 0) begin
            r.entry_class = shadow_class[shadow_depth - 1];
            r.entry_line  = shadow_line[shadow_depth - 1];
         end
         r.stack_depth = (shadow_depth > DEPTH_OUT_MAX) ? 6'(DEPTH_OUT_MAX) : 6'(shadow_depth);
         r.overflowed  = shadow_overflow;
         r.last        = 1'b1;
         expected_rsp.push_back(r);
      end else begin
         drain_count++;
         total = 0;
         for (int i = 0; i < shadow_depth; i++)
            if (!is_accepted(shadow_class[i])) total++;
         if (total > RESULT_LIMIT) total = RESULT_LIMIT;
         produced = 0;
         for (int i = 0; i < shadow_depth && produced < total; i++) begin
            if (!is_accepted(shadow_class[i])) begin
               r = '0;
               r.kind        = KIND_LEFTOVER;
               r.entry_class = shadow_class[i];
               r.entry_line  = shadow_line[i];
               r.overflowed  = shadow_overflow;
               r.last        = (produced == total - 1);
               expected_rsp.push_back(r);
               produced++;
               leftover_count++;
            end
         end
         if (total == 0) begin
            r = '0;
            r.kind       = KIND_NO_ERROR;
            r.overflowed = shadow_overflow;
            r.last       = 1'b1;
            expected_rsp.push_back(r);
         end
         shadow_depth    = 0;
         shadow_overflow = 1'b0;
      end
   endfunction

   function automatic req_item_type make_item(input logic cmd_bit, input class_type cls,
                                              input line_type ln);
      req_item_type it;
      it.cmd         = cmd_bit;
      it.token_class = cls;
      it.line_number = ln;
      return it;
   endfunction

   // tokens of one rule, an identifier optionally expanded into an identifier phrase
   function automatic void add_rule_tokens(input int r, input bit nest);
      for (int j = 0; j < RULE_LEN[r]; j++) begin
         if (nest && RULE_SEQ[r][j] == CLS_ID && $urandom_range(3) == 0)
            add_rule_tokens($urandom_range(RULE_COUNT - 1, 7), 1'b0);
         else
            phrase_q.push_back(RULE_SEQ[r][j]);
      end
   endfunction

   task automatic send_item(input req_item_type it);
      if ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         start = 1'b0;
         repeat ($urandom_range(3)) @(negedge clock);
      end
      @(negedge clock);
      req_item = it;
      start    = 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      predict_step(it);
   endtask

   task automatic shift_token(input class_type cls, input line_type ln);
      send_item(make_item(CMD_SHIFT, cls, ln));
   endtask

   // token class and line are don't-care on a drain
   task automatic drain_stack();
      send_item(make_item(CMD_DRAIN, class_type'($urandom_range(63)), line_type'($urandom)));
   endtask

   task automatic wait_for_quiet();
      @(negedge clock);
      start = 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      idle_pct = 0;
      drain_stack();
      shift_token(CLS_END, 16'h0000);
      shift_token(6'd63, 16'hFFFF);
      shift_token(6'd60, 16'hAAAA);
      shift_token(CLS_DEF, 16'h5555);
      drain_stack();
      send_item(make_item(CMD_DRAIN, 6'd59, 16'hFFFF));
      shift_token(CLS_ID, 16'd10);
      shift_token(CLS_DOT, 16'd11);
      shift_token(CLS_ID, 16'd12);
      drain_stack();
      shift_token(CLS_VAR, 16'd20);
      shift_token(CLS_ID, 16'd21);
      shift_token(CLS_EQ, 16'd22);
      shift_token(CLS_FUNCTION, 16'd23);
      drain_stack();
   endtask

   task automatic test_every_rule();
      idle_pct = 0;
      for (int r = 0; r < RULE_COUNT; r++) begin
         phrase_q.delete();
         add_rule_tokens(r, 1'b0);
         for (int k = 0; k < phrase_q.size(); k++)
            shift_token(phrase_q[k], line_type'($urandom));
      end
      drain_stack();
   endtask

   task automatic test_overflow();
      class_type cls;
      idle_pct = 0;
      // no rule can start without var or identifier, so nothing reduces
      for (int k = 0; k < STACK_DEPTH_DEF + 2; k++) begin
         cls = class_type'($urandom_range(63));
         if (cls == CLS_VAR || cls == CLS_ID) cls = CLS_SEMI;
         shift_token(cls, line_type'($urandom));
      end
      drain_stack();
      shift_token(CLS_SEMI, line_type'($urandom));
      drain_stack();
   endtask

   task automatic test_random(input int n_items, input int pct);
      int sent;
      int pick;
      sent = 0;
      idle_pct = pct;
      while (sent < n_items) begin
         pick = $urandom_range(99);
         if (shadow_depth > 26 && $urandom_range(1) == 0) begin
            drain_stack();
            sent++;
         end else if (pick < 70) begin
            phrase_q.delete();
            add_rule_tokens($urandom_range(RULE_COUNT - 1), 1'b1);
            if ($urandom_range(9) == 0)
               phrase_q[$urandom_range(phrase_q.size() - 1)] = class_type'($urandom_range(63));
            if ($urandom_range(9) == 0) void'(phrase_q.pop_back());
            for (int k = 0; k < phrase_q.size(); k++)
               shift_token(phrase_q[k], line_type'($urandom));
            sent += phrase_q.size();
            if ($urandom_range(2) == 0) begin
               drain_stack();
               sent++;
            end
         end else if (pick < 85) begin
            shift_token(class_type'($urandom_range(63)), line_type'($urandom));
            sent++;
         end else begin
            drain_stack();
            sent++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1) begin
         if (expected_rsp.size() == 0) begin
            fail_count++;
            $display("%0t ns: unexpected result, expected none, actual kind %0d class %0d line %0d",
                     $time, rsp_item.kind, rsp_item.entry_class, rsp_item.entry_line);
         end else begin
            want_rsp = expected_rsp.pop_front();
            checked_count++;
            if (rsp_item.kind !== want_rsp.kind ||
                rsp_item.entry_class !== want_rsp.entry_class ||
                rsp_item.entry_line !== want_rsp.entry_line ||
                rsp_item.stack_depth !== want_rsp.stack_depth ||
                rsp_item.overflowed !== want_rsp.overflowed ||
                rsp_item.last !== want_rsp.last) begin
               fail_count++;
               $display("%0t ns: mismatch, expected kind %0d class %0d line %0d depth %0d ovf %0d last %0d",
                        $time, want_rsp.kind, want_rsp.entry_class, want_rsp.entry_line,
                        want_rsp.stack_depth, want_rsp.overflowed, want_rsp.last);
               $display("%0t ns: mismatch, actual   kind %0d class %0d line %0d depth %0d ovf %0d last %0d",
                        $time, rsp_item.kind, rsp_item.entry_class, rsp_item.entry_line,
                        rsp_item.stack_depth, rsp_item.overflowed, rsp_item.last);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t ns: timeout with %0d results outstanding", $time, expected_rsp.size());
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      reset    = 1'b1;
      start    = 1'b0;
      req_item = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_every_rule();
      test_overflow();
      test_random(4, 0);
      test_random(4, 53);
      wait_for_quiet();
      test_random(4, 22);
      test_random(4, 0);

      @(negedge clock);
      start = 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d shifts, %0d drains, %0d reductions, %0d leftovers, %0d dropped pushes",
               shift_count, drain_count, reduce_count, leftover_count, dropped_count);
      $display("%0d results checked, %0d failures", checked_count, fail_count);
      if (fail_count == 0 && expected_rsp.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
